### rtl/core/gtu_pkg.sv
package gtu_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 20;
  localparam int unsigned OUT_FRAC_BITS   = 30;

  localparam int unsigned LON_W   = 29;
  localparam int unsigned LAT_W   = 28;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned ANG_W   = LON_W;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_Q60 = PI_Q60 / 64'd180;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
  localparam int unsigned TERMS   = 8;

  // angle reduction: whole degrees taken modulo 360 by reciprocal
  localparam int unsigned AHW = ANG_W - ANGLE_FRAC_BITS;
  localparam int unsigned UW  = AHW + 10;
  localparam int unsigned RS  = UW + 9;
  localparam longint unsigned OFF = 360 * (((64'd1 << (AHW - 1)) + 359) / 360);
  localparam logic [63:0] MOD_REC = ((64'd1 << RS) + 64'd359) / 64'd360;
  localparam int unsigned TW  = 6 + ANGLE_FRAC_BITS;
  localparam logic [63:0] EIGHTH = 64'd45 << ANGLE_FRAC_BITS;

  // pipeline timing
  localparam int unsigned MUL_LAT  = 2;
  localparam int unsigned STEP_LAT = 2 * MUL_LAT;
  localparam int unsigned X_DLY    = MUL_LAT + TERMS * STEP_LAT;
  localparam int unsigned OCT_DLY  = 3 * MUL_LAT + TERMS * STEP_LAT;
  localparam int unsigned LANE_LAT = 2 + 3 * MUL_LAT + TERMS * STEP_LAT + 1;
  localparam int unsigned LAT      = LANE_LAT + MUL_LAT + 1;

  // output rounding and saturation
  localparam int unsigned OUT_SH = 60 - OUT_FRAC_BITS;
  localparam logic [63:0] OUT_LIMIT = (OUT_FRAC_BITS > 30) ? 64'h7FFFFFFF :
                                      (64'd1 << OUT_FRAC_BITS);

  typedef struct packed {
    logic [63:0] s_mag;
    logic        s_neg;
    logic [63:0] c_mag;
    logic        c_neg;
  } sincos_t;

endpackage

### rtl/core/gtu_mul.sv
module gtu_mul (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);

  logic [63:0]  pll_q, plh_q, phl_q, phh_q;
  logic [127:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
      plh_q <= 64'(a_i[31:0]) * 64'(b_i[63:32]);
      phl_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      phh_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 128'(pll_q) + (128'(plh_q) << 32) + (128'(phl_q) << 32) + (128'(phh_q) << 64);
    end
  end

  assign p_o = p_q;

endmodule

### rtl/core/gtu_horner.sv
module gtu_horner (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x2_i,
  input  logic [63:0] ps_i,
  input  logic [63:0] pc_i,
  input  logic [63:0] ms_i,
  input  logic [63:0] mc_i,
  input  logic [6:0]  ss_i,
  input  logic [6:0]  sc_i,
  output logic [63:0] x2_o,
  output logic [63:0] ps_o,
  output logic [63:0] pc_o
);

  logic [127:0] pa, pb, qa, qb;
  logic [63:0]  x2_q [0:gtu_pkg::STEP_LAT-1];

  // x2 * p, then divide by the term constant through its reciprocal
  gtu_mul u_mul_sa (.clk_i, .en_i, .a_i(x2_i), .b_i(ps_i), .p_o(pa));
  gtu_mul u_mul_ca (.clk_i, .en_i, .a_i(x2_i), .b_i(pc_i), .p_o(pb));
  gtu_mul u_mul_sd (.clk_i, .en_i, .a_i(pa[60 +: 64]), .b_i(ms_i), .p_o(qa));
  gtu_mul u_mul_cd (.clk_i, .en_i, .a_i(pb[60 +: 64]), .b_i(mc_i), .p_o(qb));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q[0] <= x2_i;
      for (int i = 1; i < gtu_pkg::STEP_LAT; i++) begin
        x2_q[i] <= x2_q[i-1];
      end
    end
  end

  assign x2_o = x2_q[gtu_pkg::STEP_LAT-1];
  assign ps_o = gtu_pkg::ONE_Q60 - 64'(qa >> ss_i);
  assign pc_o = gtu_pkg::ONE_Q60 - 64'(qb >> sc_i);

endmodule

### rtl/core/gtu_sincos.sv
module gtu_sincos (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [gtu_pkg::ANG_W-1:0] ang_i,
  output gtu_pkg::sincos_t          sc_o
);

  localparam int unsigned AFB = gtu_pkg::ANGLE_FRAC_BITS;
  localparam int unsigned UW  = gtu_pkg::UW;
  localparam int unsigned TW  = gtu_pkg::TW;

  logic [gtu_pkg::AHW-1:0] ahi;
  logic [UW-1:0]           u;
  logic [63:0]             qp;
  logic [UW-1:0]           u_q, q_q;
  logic [AFB-1:0]          frac_q;
  logic [8:0]              d;
  logic [2:0]              oct;
  logic [5:0]              remd;
  logic [TW-1:0]           rem, t_d, t_q;
  logic [2:0]              oct_q;
  logic [2:0]              oct_dly_q [0:gtu_pkg::OCT_DLY-1];
  logic [127:0]            xp, x2p, sp;
  logic [63:0]             x, s;
  logic [63:0]             x_dly_q [0:gtu_pkg::X_DLY-1];
  logic [63:0]             pc_dly_q [0:gtu_pkg::MUL_LAT-1];
  logic [63:0]             x2_c [0:gtu_pkg::TERMS];
  logic [63:0]             ps_c [0:gtu_pkg::TERMS];
  logic [63:0]             pc_c [0:gtu_pkg::TERMS];
  logic [2:0]              oo;
  logic                    same;
  gtu_pkg::sincos_t        sc_q;

  // whole degrees modulo 360
  assign ahi = ang_i[gtu_pkg::ANG_W-1:AFB];
  assign u   = {{(UW - gtu_pkg::AHW){ahi[gtu_pkg::AHW-1]}}, ahi} + UW'(gtu_pkg::OFF);
  assign qp  = 64'(u) * gtu_pkg::MOD_REC;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q    <= u;
      q_q    <= UW'(qp >> gtu_pkg::RS);
      frac_q <= ang_i[AFB-1:0];
    end
  end

  // octant and fold
  always_comb begin
    d   = 9'(u_q - q_q * UW'(360));
    oct = '0;
    for (int k = 1; k < 8; k++) begin
      oct = oct + 3'(d >= 9'(45 * k));
    end
    remd = 6'(d - 9'(oct) * 9'd45);
    rem  = {remd, frac_q};
    t_d  = oct[0] ? TW'(gtu_pkg::EIGHTH) - rem : rem;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= t_d;
      oct_q <= oct;
    end
  end

  gtu_mul u_mul_x (.clk_i, .en_i, .a_i(64'(t_q)), .b_i(gtu_pkg::DEG_Q60), .p_o(xp));
  assign x = xp[AFB +: 64];

  gtu_mul u_mul_x2 (.clk_i, .en_i, .a_i(x), .b_i(x), .p_o(x2p));

  assign x2_c[0] = x2p[60 +: 64];
  assign ps_c[0] = gtu_pkg::ONE_Q60;
  assign pc_c[0] = gtu_pkg::ONE_Q60;

  for (genvar i = 0; i < gtu_pkg::TERMS; i++) begin : g_term
    localparam int unsigned K  = gtu_pkg::TERMS - i;
    localparam int unsigned DS = (2 * K) * (2 * K + 1);
    localparam int unsigned DC = (2 * K - 1) * (2 * K);
    localparam int unsigned SS = 61 + $clog2(DS);
    localparam int unsigned SC = 61 + $clog2(DC);
    localparam logic [127:0] MS = ((128'd1 << SS) + 128'(DS) - 128'd1) / 128'(DS);
    localparam logic [127:0] MC = ((128'd1 << SC) + 128'(DC) - 128'd1) / 128'(DC);

    gtu_horner u_step (
      .clk_i,
      .en_i,
      .x2_i(x2_c[i]),
      .ps_i(ps_c[i]),
      .pc_i(pc_c[i]),
      .ms_i(MS[63:0]),
      .mc_i(MC[63:0]),
      .ss_i(7'(SS)),
      .sc_i(7'(SC)),
      .x2_o(x2_c[i+1]),
      .ps_o(ps_c[i+1]),
      .pc_o(pc_c[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_dly_q[0]   <= x;
      oct_dly_q[0] <= oct_q;
      pc_dly_q[0]  <= pc_c[gtu_pkg::TERMS];
      for (int i = 1; i < gtu_pkg::X_DLY; i++) begin
        x_dly_q[i] <= x_dly_q[i-1];
      end
      for (int i = 1; i < gtu_pkg::OCT_DLY; i++) begin
        oct_dly_q[i] <= oct_dly_q[i-1];
      end
      for (int i = 1; i < gtu_pkg::MUL_LAT; i++) begin
        pc_dly_q[i] <= pc_dly_q[i-1];
      end
    end
  end

  gtu_mul u_mul_s (
    .clk_i, .en_i, .a_i(x_dly_q[gtu_pkg::X_DLY-1]), .b_i(ps_c[gtu_pkg::TERMS]), .p_o(sp)
  );
  assign s = sp[60 +: 64];

  // octant map: swap on octants 1, 2, 5, 6
  assign oo   = oct_dly_q[gtu_pkg::OCT_DLY-1];
  assign same = (oo[0] == oo[1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q.s_mag <= same ? s : pc_dly_q[gtu_pkg::MUL_LAT-1];
      sc_q.c_mag <= same ? pc_dly_q[gtu_pkg::MUL_LAT-1] : s;
      sc_q.s_neg <= oo[2];
      sc_q.c_neg <= oo[2] ^ oo[1];
    end
  end

  assign sc_o = sc_q;

endmodule

### rtl/core/geodetic_to_unit_vector.sv
// channel   dir   signals                 tdata fields (lsb up)
// s_axis    in    s_tvalid/tready/tdata   lon_deg[28:0], lat_deg[56:29], zero fill
// m_axis    out   m_tvalid/tready/tdata   x_coord[31:0], y_coord[63:32], z_coord[95:64]
//
// one word per cycle in and out while the output is not stalled; the pipeline depth is set by the chain of
// eight series steps, each two chained 64-bit multiplies built from 32x32 partial products
// reset clears only the valid bits of the pipeline
// a stalled output word holds the whole pipeline, and s_tready_o drops with it
module geodetic_to_unit_vector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] s_tdata_i,  // lon_deg, lat_deg, zero fill
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [95:0] m_tdata_o   // x_coord, y_coord, z_coord
);

  localparam int unsigned LAT = gtu_pkg::LAT;
  localparam int unsigned CW  = gtu_pkg::COORD_W;

  logic                      en;
  logic [LAT-1:0]            vld_q;
  logic [gtu_pkg::ANG_W-1:0] lon, lat;
  gtu_pkg::sincos_t          sc_lon, sc_lat;
  logic [127:0]              xp, yp;
  logic                      xn_q [0:gtu_pkg::MUL_LAT-1];
  logic                      yn_q [0:gtu_pkg::MUL_LAT-1];
  logic                      zn_q [0:gtu_pkg::MUL_LAT-1];
  logic [63:0]               zm_q [0:gtu_pkg::MUL_LAT-1];
  logic [CW-1:0]             x_q, y_q, z_q;

  function automatic logic [CW-1:0] to_coord(input logic [63:0] mag, input logic neg);
    logic [64:0] m;
    logic [64:0] r;
    m = (65'(mag) + (65'd1 << (gtu_pkg::OUT_SH - 1))) >> gtu_pkg::OUT_SH;
    if (m > 65'(gtu_pkg::OUT_LIMIT)) begin
      m = 65'(gtu_pkg::OUT_LIMIT);
    end
    r = neg ? 65'(0) - m : m;
    return r[CW-1:0];
  endfunction

  assign en         = ~m_tvalid_o | m_tready_i;
  assign s_tready_o = en;

  assign lon = s_tdata_i[gtu_pkg::LON_W-1:0];
  assign lat = {{(gtu_pkg::ANG_W - gtu_pkg::LAT_W){s_tdata_i[gtu_pkg::LON_W+gtu_pkg::LAT_W-1]}},
                s_tdata_i[gtu_pkg::LON_W +: gtu_pkg::LAT_W]};

  gtu_sincos u_lon (.clk_i, .en_i(en), .ang_i(lon), .sc_o(sc_lon));
  gtu_sincos u_lat (.clk_i, .en_i(en), .ang_i(lat), .sc_o(sc_lat));

  gtu_mul u_mul_x (.clk_i, .en_i(en), .a_i(sc_lon.s_mag), .b_i(sc_lat.c_mag), .p_o(xp));
  gtu_mul u_mul_y (.clk_i, .en_i(en), .a_i(sc_lon.c_mag), .b_i(sc_lat.c_mag), .p_o(yp));

  always_ff @(posedge clk_i) begin
    if (en) begin
      xn_q[0] <= sc_lon.s_neg ^ sc_lat.c_neg;
      yn_q[0] <= sc_lon.c_neg ^ sc_lat.c_neg;
      zn_q[0] <= sc_lat.s_neg;
      zm_q[0] <= sc_lat.s_mag;
      for (int i = 1; i < gtu_pkg::MUL_LAT; i++) begin
        xn_q[i] <= xn_q[i-1];
        yn_q[i] <= yn_q[i-1];
        zn_q[i] <= zn_q[i-1];
        zm_q[i] <= zm_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= to_coord(xp[60 +: 64], xn_q[gtu_pkg::MUL_LAT-1]);
      y_q <= to_coord(yp[60 +: 64], yn_q[gtu_pkg::MUL_LAT-1]);
      z_q <= to_coord(zm_q[gtu_pkg::MUL_LAT-1], zn_q[gtu_pkg::MUL_LAT-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_tvalid_i};
    end
  end

  assign m_tvalid_o = vld_q[LAT-1];
  assign m_tdata_o  = {z_q, y_q, x_q};

`ifndef SYNTHESIS
  localparam logic signed [CW:0] LIM_S = (CW + 1)'(gtu_pkg::OUT_LIMIT);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |-> !s_tready_o)
    else $error("input taken while output word stalls");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed({x_q[CW-1], x_q}) <= LIM_S && $signed({x_q[CW-1], x_q}) >= -LIM_S))
    else $error("x_coord beyond unit range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed({y_q[CW-1], y_q}) <= LIM_S && $signed({y_q[CW-1], y_q}) >= -LIM_S))
    else $error("y_coord beyond unit range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed({z_q[CW-1], z_q}) <= LIM_S && $signed({z_q[CW-1], z_q}) >= -LIM_S))
    else $error("z_coord beyond unit range");
`endif

endmodule

### test/geodetic_to_unit_vector_checker.sv
`timescale 1ns / 100ps

module geodetic_to_unit_vector_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,   // lon_deg, lat_deg, zero fill
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [95:0] m_tdata_i,   // x_coord, y_coord, z_coord
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned CW  = gtu_pkg::COORD_W;
  localparam int unsigned AFB = gtu_pkg::ANGLE_FRAC_BITS;

  typedef struct {
    logic [63:0] mag;
    logic        neg;
  } signed_mag_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } unit_vec_t;

  unit_vec_t vec_q[$];
  int        fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = vec_q.size();

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    return 64'(p >> sh);
  endfunction

  // sine and cosine of an angle in input units
  function automatic void angle_sincos(longint ang, output signed_mag_t sn,
                                       output signed_mag_t cs);
    longint      full;
    longint      eighth;
    longint      r;
    longint      oct;
    longint      t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ps;
    logic [63:0] pc;
    logic [63:0] s;
    logic [63:0] c;
    full   = longint'(360) << AFB;
    eighth = longint'(45) << AFB;
    r = ang % full;
    if (r < 0) r += full;
    oct = r / eighth;
    t = r - oct * eighth;
    if (oct[0]) t = eighth - t;
    x  = q_mul(64'(t), gtu_pkg::DEG_Q60, AFB);
    x2 = q_mul(x, x, 60);
    ps = gtu_pkg::ONE_Q60;
    pc = gtu_pkg::ONE_Q60;
    for (int k = gtu_pkg::TERMS; k >= 1; k--) begin
      ps = gtu_pkg::ONE_Q60 - q_mul(x2, ps, 60) / 64'((2 * k) * (2 * k + 1));
      pc = gtu_pkg::ONE_Q60 - q_mul(x2, pc, 60) / 64'((2 * k - 1) * (2 * k));
    end
    s = q_mul(x, ps, 60);
    c = pc;
    case (oct[2:0])
      3'd0: begin sn = '{s, 0}; cs = '{c, 0}; end
      3'd1: begin sn = '{c, 0}; cs = '{s, 0}; end
      3'd2: begin sn = '{c, 0}; cs = '{s, 1}; end
      3'd3: begin sn = '{s, 0}; cs = '{c, 1}; end
      3'd4: begin sn = '{s, 1}; cs = '{c, 1}; end
      3'd5: begin sn = '{c, 1}; cs = '{s, 1}; end
      3'd6: begin sn = '{c, 1}; cs = '{s, 0}; end
      default: begin sn = '{s, 1}; cs = '{c, 0}; end
    endcase
  endfunction

  function automatic logic [CW-1:0] round_coord(signed_mag_t v);
    logic [63:0] m;
    logic [63:0] lim;
    lim = 64'd1 << gtu_pkg::OUT_FRAC_BITS;
    if (lim > 64'h7FFFFFFF) lim = 64'h7FFFFFFF;
    m = (v.mag + (64'd1 << (gtu_pkg::OUT_SH - 1))) >> gtu_pkg::OUT_SH;
    if (m > lim) m = lim;
    if (v.neg) m = 64'd0 - m;
    return m[CW-1:0];
  endfunction

  function automatic unit_vec_t unit_vector(logic [63:0] word);
    signed_mag_t slon, clon, slat, clat, xm, ym;
    unit_vec_t   v;
    angle_sincos(longint'($signed(word[gtu_pkg::LON_W-1:0])), slon, clon);
    angle_sincos(longint'($signed(word[gtu_pkg::LON_W+gtu_pkg::LAT_W-1:gtu_pkg::LON_W])),
                 slat, clat);
    xm = '{q_mul(slon.mag, clat.mag, 60), slon.neg ^ clat.neg};
    ym = '{q_mul(clon.mag, clat.mag, 60), clon.neg ^ clat.neg};
    v.x = round_coord(xm);
    v.y = round_coord(ym);
    v.z = round_coord(slat);
    return v;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk_i) begin
    unit_vec_t want;
    if (rst_ni && s_tvalid_i && s_tready_i) vec_q.push_back(unit_vector(s_tdata_i));
    if (rst_ni && m_tvalid_i && m_tready_i) begin
      if (vec_q.size() == 0) begin
        report("unexpected word", m_tdata_i[31:0], '0);
      end else begin
        want = vec_q.pop_front();
        if (m_tdata_i[31:0] !== want.x) report("x_coord", m_tdata_i[31:0], want.x);
        if (m_tdata_i[63:32] !== want.y) report("y_coord", m_tdata_i[63:32], want.y);
        if (m_tdata_i[95:64] !== want.z) report("z_coord", m_tdata_i[95:64], want.z);
      end
    end
  end

endmodule

### test/geodetic_to_unit_vector_test.sv
`timescale 1ns / 100ps

module geodetic_to_unit_vector_test;

  localparam int AFB          = gtu_pkg::ANGLE_FRAC_BITS;
  localparam int RANDOM_WORDS = 1830;
  localparam int IDLE_LIMIT   = 20000;
  localparam int LON_MAX      = 180 << AFB;
  localparam int LAT_MAX      = 90 << AFB;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  int          fail_count;
  int          pending;
  int          idle_cycles;

  geodetic_to_unit_vector dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata)
  );

  geodetic_to_unit_vector_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 60);
  endfunction

  // receiver stalls
  initial begin
    int n;
    m_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      m_tready <= 1'b1;
      n = (($urandom_range(0, 3) == 0) ? 40 : 1) * $urandom_range(1, 8);
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [gtu_pkg::LON_W-1:0] lon, logic [gtu_pkg::LAT_W-1:0] lat);
    int n;
    n = gap_len();
    if ($urandom_range(0, 7) < 3) n = 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lat, lon};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] rand_angle(int lim);
    int oct;
    int off;
    oct = int'($urandom_range(0, 16)) - 8;
    off = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return (oct * 45) << AFB;
      2: return ((oct * 45) << AFB) + off;
      default: return $urandom_range(0, 2 * lim) - lim;
    endcase
  endfunction

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    rst_n    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_word(29'(LON_MAX), 28'(LAT_MAX));
    send_word(29'(-LON_MAX), 28'(-LAT_MAX));
    send_word('0, '0);
    send_word(29'h0FFF_FFFF, 28'h7FF_FFFF);
    send_word(29'h1000_0000, 28'h800_0000);
    send_word('1, '1);
    send_word(29'(360 << AFB), 28'(45 << AFB));
    send_word(29'(-(45 << AFB)), 28'(-(135 << AFB)));
    for (int o = 0; o < 8; o++) begin
      send_word(29'((o * 45 << AFB) + 1), 28'((o * 45 << AFB) - 1));
    end
    send_word(29'(90 << AFB), 28'(90 << AFB) - 28'd1);
    send_word(29'(270 << AFB), 28'(-(90 << AFB)));
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 600 == 300) begin
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_word(29'(rand_angle(LON_MAX)), 28'(rand_angle(LAT_MAX)));
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2 * gtu_pkg::LAT + 10) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog on cycles without any accepted word
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
